/* rtl/hhc_pkg.sv */
// ----------------------------------------------------------------------------
// hhc_pkg - shared types and constants of the heading hold controller
// Item formats, register indexes, fixed-point widths and the command and
// status bundles that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package hhc_pkg;

    // Angles in 1/128 degree
    localparam int ANGLE_W = 16;
    localparam int DIFF_W  = ANGLE_W + 1;
    localparam int CORR_W  = 16;
    localparam int GAIN_W  = 8;
    localparam int MAXC_W  = 15;
    localparam int DB_W    = 11;
    localparam int ALPHA_W = 9;
    localparam int PROD_W  = ANGLE_W + GAIN_W + 1;
    localparam int MUL_W   = CORR_W + ALPHA_W + 1;
    localparam int ACC_W   = MUL_W + 1;

    localparam logic signed [DIFF_W-1:0] HALF_TURN = DIFF_W'(23040);
    localparam logic signed [DIFF_W-1:0] FULL_TURN = DIFF_W'(46080);
    localparam logic [ALPHA_W-1:0]       ALPHA_ONE = ALPHA_W'(256);

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CORR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT   = 3'd4;

    localparam logic [GAIN_W-1:0]  GAIN_RST     = 8'd128;
    localparam logic [MAXC_W-1:0]  MAX_CORR_RST = 15'd5760;
    localparam logic [DB_W-1:0]    DEADBAND_RST = 11'd64;
    localparam logic [ALPHA_W-1:0] ALPHA_RST    = 9'd115;
    localparam logic               INVERT_RST   = 1'b1;

    // Item kinds
    localparam logic [1:0] MODE_YAW     = 2'd0;
    localparam logic [1:0] MODE_MOVING  = 2'd1;
    localparam logic [1:0] MODE_CORRECT = 2'd2;

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [ANGLE_W-1:0] yaw;
        logic                      moving;
        logic signed [15:0]        turn_cmd;
    } in_item_t;

    typedef struct packed {
        logic signed [CORR_W-1:0] correction;
        logic                     bypassed;
        logic                     holding;
    } out_item_t;

    typedef struct packed {
        logic latch;
        logic set_yaw;
        logic set_moving;
        logic bypass;
        logic idle_res;
        logic start_hold;
        logic calc_err;
        logic calc_mul;
        logic calc_corr;
        logic calc_filt;
        logic calc_round;
        logic calc_res;
        logic push;
    } hhc_cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       manual_nz;
        logic       vehicle_moving;
        logic       hold_active;
        logic       out_free;
    } hhc_stat_t;

endpackage

/* rtl/heading_hold_controller.sv */
// ----------------------------------------------------------------------------
// heading_hold_controller - proportional heading hold with deadband
// Input transactions carry a yaw sample, a moving flag or a correction
// request; only a correction request gives an output transaction.
// Both channels use valid/ready; one transaction is worked on at a time.
// Steps of the sequencer for each kind, from acceptance:
//   yaw sample, moving notification: decode and update, then idle again.
//   request with manual yaw, while stopped, or starting a hold: decode,
//   then the result is pushed into the output register.
//   full correction: error, gain multiply, clamp, two filter multiplies,
//   rounding, output scaling, then the result is pushed.
// The result sits in an output register; the next input transaction is taken
// while it waits. If the receiver stalls and a second result is ready, the
// block holds in its final step until the register frees up.
// Reset clears headings, hold and filter state and loads the register
// defaults: gain 8.0, clamp 45 degrees, deadband 0.5 degree, alpha 115/256,
// output inverted. Configuration writes take effect at once; they must be
// made only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module heading_hold_controller (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  hhc_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output hhc_pkg::out_item_t             out_data,
    input  logic                           cfg_we,
    input  logic [hhc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hhc_pkg::CFG_DATA_W-1:0] cfg_data
);

    hhc_pkg::hhc_cmd_t  cmd;
    hhc_pkg::hhc_stat_t stat;

    hhc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    hhc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

/* rtl/hhc_ctrl.sv */
// ----------------------------------------------------------------------------
// hhc_ctrl - sequencer of the heading hold controller
// Takes one transaction at a time and decodes its kind; a full correction
// steps the datapath through error, gain, clamp, filter and output stages.
// ----------------------------------------------------------------------------
module hhc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  hhc_pkg::hhc_stat_t stat,
    output hhc_pkg::hhc_cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_ERR    = 4'd2;
    localparam logic [3:0] ST_MUL    = 4'd3;
    localparam logic [3:0] ST_CLAMP  = 4'd4;
    localparam logic [3:0] ST_FILT   = 4'd5;
    localparam logic [3:0] ST_ROUND  = 4'd6;
    localparam logic [3:0] ST_RESULT = 4'd7;
    localparam logic [3:0] ST_EMIT   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.latch = in_valid;
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (stat.mode)
                    hhc_pkg::MODE_YAW:
                    begin
                        cmd.set_yaw = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    hhc_pkg::MODE_MOVING:
                    begin
                        cmd.set_moving = 1'b1;
                        state_next     = ST_IDLE;
                    end
                    hhc_pkg::MODE_CORRECT:
                    begin
                        if (stat.manual_nz)
                        begin
                            cmd.bypass = 1'b1;
                            state_next = ST_EMIT;
                        end
                        else if (!stat.vehicle_moving)
                        begin
                            cmd.idle_res = 1'b1;
                            state_next   = ST_EMIT;
                        end
                        else if (!stat.hold_active)
                        begin
                            cmd.start_hold = 1'b1;
                            state_next     = ST_EMIT;
                        end
                        else
                        begin
                            state_next = ST_ERR;
                        end
                    end
                    default:
                    begin
                        // unused kind: drop
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_ERR:
            begin
                cmd.calc_err = 1'b1;
                state_next   = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.calc_mul = 1'b1;
                state_next   = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                cmd.calc_corr = 1'b1;
                state_next    = ST_FILT;
            end
            ST_FILT:
            begin
                cmd.calc_filt = 1'b1;
                state_next    = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.calc_round = 1'b1;
                state_next     = ST_RESULT;
            end
            ST_RESULT:
            begin
                cmd.calc_res = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_EMIT:
            begin
                // hold until the output register is free
                if (stat.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/hhc_datapath.sv */
// ----------------------------------------------------------------------------
// hhc_datapath - arithmetic and state of the heading hold controller
// Holds the configuration, headings, hold flags and filter state, the
// pipeline registers of the correction path and the output register.
// ----------------------------------------------------------------------------
module hhc_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  hhc_pkg::hhc_cmd_t                   cmd,
    output hhc_pkg::hhc_stat_t                  stat,
    input  hhc_pkg::in_item_t                   in_data,
    input  logic                                cfg_we,
    input  logic [hhc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hhc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output hhc_pkg::out_item_t                  out_data
);

    // configuration
    logic [hhc_pkg::GAIN_W-1:0]  gain_reg;
    logic [hhc_pkg::MAXC_W-1:0]  max_corr_reg;
    logic [hhc_pkg::DB_W-1:0]    deadband_reg;
    logic [hhc_pkg::ALPHA_W-1:0] alpha_reg;
    logic                        invert_reg;

    // controller state
    logic signed [hhc_pkg::ANGLE_W-1:0] cur_reg, cur_next;
    logic signed [hhc_pkg::ANGLE_W-1:0] ref_reg, ref_next;
    logic                               hold_reg, hold_next;
    logic                               moving_reg, moving_next;
    logic                               prev_reg, prev_next;
    logic signed [hhc_pkg::CORR_W-1:0]  filt_reg, filt_next;

    // pipeline
    hhc_pkg::in_item_t                  item_reg;
    logic signed [hhc_pkg::ANGLE_W-1:0] err_reg, err_next;
    logic signed [hhc_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic signed [hhc_pkg::CORR_W-1:0]  corr_reg, corr_next;
    logic signed [hhc_pkg::MUL_W-1:0]   mul_a_reg, mul_a_next;
    logic signed [hhc_pkg::MUL_W-1:0]   mul_b_reg, mul_b_next;
    hhc_pkg::out_item_t                 res_reg, res_next;
    hhc_pkg::out_item_t                 out_data_reg;
    logic                               out_valid_reg, out_valid_next;

    // combinational intermediates
    logic signed [hhc_pkg::DIFF_W-1:0]  yaw_ext, yaw_wrap;
    logic signed [hhc_pkg::DIFF_W-1:0]  diff, err_wrap, db_s;
    logic signed [hhc_pkg::PROD_W-1:0]  lim, clamp_val, clamp_bias;
    logic [hhc_pkg::ALPHA_W-1:0]        alpha_eff, beta;
    logic signed [hhc_pkg::ACC_W-1:0]   sum;
    logic [hhc_pkg::ACC_W-1:0]          mag, mag_rnd;
    logic [hhc_pkg::CORR_W-1:0]         q_mag;
    logic signed [hhc_pkg::CORR_W-1:0]  filt_round;
    logic signed [hhc_pkg::CORR_W:0]    fv, v, v_bias;
    logic signed [hhc_pkg::CORR_W-1:0]  out_corr;

    // wrap the incoming yaw once into the half-turn range
    always_comb
    begin
        yaw_ext = {item_reg.yaw[hhc_pkg::ANGLE_W-1], item_reg.yaw};
        if (yaw_ext > hhc_pkg::HALF_TURN)
        begin
            yaw_wrap = yaw_ext - hhc_pkg::FULL_TURN;
        end
        else if (yaw_ext < -hhc_pkg::HALF_TURN)
        begin
            yaw_wrap = yaw_ext + hhc_pkg::FULL_TURN;
        end
        else
        begin
            yaw_wrap = yaw_ext;
        end
    end

    // error: reference minus current, wrapped once, zeroed inside the deadband
    always_comb
    begin
        diff = {ref_reg[hhc_pkg::ANGLE_W-1], ref_reg}
             - {cur_reg[hhc_pkg::ANGLE_W-1], cur_reg};
        if (diff > hhc_pkg::HALF_TURN)
        begin
            err_wrap = diff - hhc_pkg::FULL_TURN;
        end
        else if (diff < -hhc_pkg::HALF_TURN)
        begin
            err_wrap = diff + hhc_pkg::FULL_TURN;
        end
        else
        begin
            err_wrap = diff;
        end
        db_s = hhc_pkg::DIFF_W'(deadband_reg);
        if ((err_wrap > -db_s) && (err_wrap < db_s))
        begin
            err_next = '0;
        end
        else
        begin
            err_next = err_wrap[hhc_pkg::ANGLE_W-1:0];
        end
    end

    assign prod_next = hhc_pkg::PROD_W'(err_reg)
                     * hhc_pkg::PROD_W'($signed({1'b0, gain_reg}));

    // clamp to the scaled limit, then divide by 16 towards zero
    always_comb
    begin
        lim = hhc_pkg::PROD_W'({max_corr_reg, 4'b0000});
        if (prod_reg > lim)
        begin
            clamp_val = lim;
        end
        else if (prod_reg < -lim)
        begin
            clamp_val = -lim;
        end
        else
        begin
            clamp_val = prod_reg;
        end
        clamp_bias = clamp_val + (clamp_val[hhc_pkg::PROD_W-1] ?
                                  hhc_pkg::PROD_W'(15) : hhc_pkg::PROD_W'(0));
        corr_next  = hhc_pkg::CORR_W'(clamp_bias >>> 4);
    end

    // low-pass weights
    always_comb
    begin
        alpha_eff  = (alpha_reg > hhc_pkg::ALPHA_ONE) ? hhc_pkg::ALPHA_ONE : alpha_reg;
        beta       = hhc_pkg::ALPHA_ONE - alpha_eff;
        mul_a_next = hhc_pkg::MUL_W'($signed({1'b0, alpha_eff})) * hhc_pkg::MUL_W'(corr_reg);
        mul_b_next = hhc_pkg::MUL_W'($signed({1'b0, beta})) * hhc_pkg::MUL_W'(filt_reg);
    end

    // divide the weighted sum by 256, halves away from zero
    always_comb
    begin
        sum        = hhc_pkg::ACC_W'(mul_a_reg) + hhc_pkg::ACC_W'(mul_b_reg);
        mag        = sum[hhc_pkg::ACC_W-1] ? -sum : sum;
        mag_rnd    = (mag + hhc_pkg::ACC_W'(128)) >> 8;
        q_mag      = mag_rnd[hhc_pkg::CORR_W-1:0];
        filt_round = sum[hhc_pkg::ACC_W-1] ? -$signed(q_mag) : $signed(q_mag);
    end

    // output in whole degrees, truncated towards zero
    always_comb
    begin
        fv       = {filt_reg[hhc_pkg::CORR_W-1], filt_reg};
        v        = invert_reg ? -fv : fv;
        v_bias   = v + (v[hhc_pkg::CORR_W] ? (hhc_pkg::CORR_W+1)'(127)
                                           : (hhc_pkg::CORR_W+1)'(0));
        out_corr = hhc_pkg::CORR_W'(v_bias >>> 7);
    end

    // state updates and result selection
    always_comb
    begin
        cur_next    = cur_reg;
        ref_next    = ref_reg;
        hold_next   = hold_reg;
        moving_next = moving_reg;
        prev_next   = prev_reg;
        filt_next   = filt_reg;
        res_next    = res_reg;

        if (cmd.set_yaw)
        begin
            cur_next = yaw_wrap[hhc_pkg::ANGLE_W-1:0];
        end
        if (cmd.set_moving)
        begin
            if (item_reg.moving && !prev_reg)
            begin
                ref_next  = cur_reg;
                hold_next = 1'b1;
                filt_next = '0;
            end
            else if (!item_reg.moving)
            begin
                ref_next  = cur_reg;
                hold_next = 1'b0;
                filt_next = '0;
            end
            moving_next = item_reg.moving;
            prev_next   = item_reg.moving;
        end
        if (cmd.bypass)
        begin
            hold_next           = 1'b0;
            filt_next           = '0;
            ref_next            = cur_reg;
            prev_next           = 1'b0;
            res_next.correction = item_reg.turn_cmd;
            res_next.bypassed   = 1'b1;
            res_next.holding    = 1'b0;
        end
        if (cmd.idle_res)
        begin
            res_next.correction = '0;
            res_next.bypassed   = 1'b0;
            res_next.holding    = hold_reg;
        end
        if (cmd.start_hold)
        begin
            ref_next            = cur_reg;
            hold_next           = 1'b1;
            filt_next           = '0;
            res_next.correction = '0;
            res_next.bypassed   = 1'b0;
            res_next.holding    = 1'b1;
        end
        if (cmd.calc_round)
        begin
            filt_next = filt_round;
        end
        if (cmd.calc_res)
        begin
            res_next.correction = out_corr;
            res_next.bypassed   = 1'b0;
            res_next.holding    = 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // configuration and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg      <= hhc_pkg::GAIN_RST;
            max_corr_reg  <= hhc_pkg::MAX_CORR_RST;
            deadband_reg  <= hhc_pkg::DEADBAND_RST;
            alpha_reg     <= hhc_pkg::ALPHA_RST;
            invert_reg    <= hhc_pkg::INVERT_RST;
            cur_reg       <= '0;
            ref_reg       <= '0;
            hold_reg      <= 1'b0;
            moving_reg    <= 1'b0;
            prev_reg      <= 1'b0;
            filt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    hhc_pkg::REG_GAIN:     gain_reg     <= cfg_data[hhc_pkg::GAIN_W-1:0];
                    hhc_pkg::REG_MAX_CORR: max_corr_reg <= cfg_data[hhc_pkg::MAXC_W-1:0];
                    hhc_pkg::REG_DEADBAND: deadband_reg <= cfg_data[hhc_pkg::DB_W-1:0];
                    hhc_pkg::REG_ALPHA:    alpha_reg    <= cfg_data[hhc_pkg::ALPHA_W-1:0];
                    hhc_pkg::REG_INVERT:   invert_reg   <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            cur_reg       <= cur_next;
            ref_reg       <= ref_next;
            hold_reg      <= hold_next;
            moving_reg    <= moving_next;
            prev_reg      <= prev_next;
            filt_reg      <= filt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            item_reg <= in_data;
        end
        if (cmd.calc_err)
        begin
            err_reg <= err_next;
        end
        if (cmd.calc_mul)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.calc_corr)
        begin
            corr_reg <= corr_next;
        end
        if (cmd.calc_filt)
        begin
            mul_a_reg <= mul_a_next;
            mul_b_reg <= mul_b_next;
        end
        res_reg <= res_next;
        if (cmd.push)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign stat.mode           = item_reg.mode;
    assign stat.manual_nz      = (item_reg.turn_cmd != '0);
    assign stat.vehicle_moving = moving_reg;
    assign stat.hold_active    = hold_reg;
    assign stat.out_free       = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
